// File: design/trop_pkg.sv
// Package for the TFTP request option parser: parse state and result types,
// phase and status codes, keyword strings and byte helpers. No dependencies.
`default_nettype none
package trop_pkg;

   localparam int unsigned TOKEN_MAX_DEFAULT = 32;
   localparam logic [15:0] MAX_BLOCK_SIZE_RESET = 16'd65464;

   typedef enum logic [2:0] {
      PH_OPC_HI,
      PH_OPC_LO,
      PH_NAME,
      PH_MODE,
      PH_OPT,
      PH_VAL
   } phase_type;

   typedef enum logic [1:0] {
      TGT_NONE,
      TGT_BLK,
      TGT_TMO,
      TGT_TSZ
   } target_type;

   localparam logic [2:0] ST_OK          = 3'd0;
   localparam logic [2:0] ST_MALFORMED   = 3'd1;
   localparam logic [2:0] ST_TOO_LONG    = 3'd2;
   localparam logic [2:0] ST_BAD_DIGIT   = 3'd3;
   localparam logic [2:0] ST_RANGE       = 3'd4;
   localparam logic [2:0] ST_MISSING_VAL = 3'd5;

   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_NAME = 2'd1;
   localparam logic [1:0] KIND_MODE = 2'd2;

   localparam logic [7:0] CH_NUL     = 8'h00;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CASE_SHIFT = 8'h20;

   localparam logic [55:0] KW_BLKSIZE = "blksize";
   localparam logic [55:0] KW_TIMEOUT = "timeout";
   localparam logic [39:0] KW_TSIZE   = "tsize";
   localparam int unsigned KW_BLKSIZE_LEN = 7;
   localparam int unsigned KW_TIMEOUT_LEN = 7;
   localparam int unsigned KW_TSIZE_LEN   = 5;

   localparam logic [2:0] BYTE_COUNT_SAT = 3'd4;
   localparam logic [2:0] BYTE_COUNT_MIN = 3'd3;
   localparam logic [2:0] FLAGS_ALL      = 3'b111;

   typedef struct packed {
      logic        err;
      phase_type   phase;
      logic [2:0]  byte_count;
      logic [2:0]  match_flags;
      target_type  target;
      logic [31:0] acc;
      logic [15:0] opcode;
      logic        blk_given;
      logic [15:0] blk_value;
      logic        tmo_given;
      logic [7:0]  tmo_value;
      logic        tsz_given;
      logic [31:0] tsz_value;
   } parse_state_type;

   typedef struct packed {
      logic [7:0]  text_byte;
      logic [1:0]  text_kind;
      logic        done_res;
      logic [2:0]  status;
      logic [15:0] request_opcode;
      logic        blksize_given;
      logic [15:0] blksize_value;
      logic        timeout_given;
      logic [7:0]  timeout_value;
      logic        tsize_given;
      logic [31:0] tsize_value;
   } result_type;

   function automatic parse_state_type parse_reset_value();
      parse_state_type s;
      s             = '0;
      s.phase       = PH_OPC_HI;
      s.target      = TGT_NONE;
      s.match_flags = FLAGS_ALL;
      return s;
   endfunction

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      return (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? c + CASE_SHIFT : c;
   endfunction

   function automatic logic [7:0] blksize_char(input logic [2:0] idx);
      return KW_BLKSIZE[8 * (6 - int'(idx)) +: 8];
   endfunction

   function automatic logic [7:0] timeout_char(input logic [2:0] idx);
      return KW_TIMEOUT[8 * (6 - int'(idx)) +: 8];
   endfunction

   function automatic logic [7:0] tsize_char(input logic [2:0] idx);
      logic [2:0] i;
      i = (idx > 3'd4) ? 3'd4 : idx;
      return KW_TSIZE[8 * (4 - int'(i)) +: 8];
   endfunction

endpackage
`default_nettype wire

// File: design/trop_if.sv
// Handshake channels of the TFTP request option parser: request byte channel
// and parse result channel. No dependencies.
`default_nettype none
interface trop_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] packet_byte;
   logic       last_byte;

   modport source(output valid, output packet_byte, output last_byte, input ready);
   modport sink(input valid, input packet_byte, input last_byte, output ready);
endinterface

interface trop_rsp_if;
   logic        valid;
   logic        ready;
   logic [7:0]  text_byte;
   logic [1:0]  text_kind;
   logic        done_res;
   logic [2:0]  status;
   logic [15:0] request_opcode;
   logic        blksize_given;
   logic [15:0] blksize_value;
   logic        timeout_given;
   logic [7:0]  timeout_value;
   logic        tsize_given;
   logic [31:0] tsize_value;

   modport source(output valid, output text_byte, output text_kind, output done_res,
                  output status, output request_opcode, output blksize_given,
                  output blksize_value, output timeout_given, output timeout_value,
                  output tsize_given, output tsize_value, input ready);
   modport sink(input valid, input text_byte, input text_kind, input done_res,
                input status, input request_opcode, input blksize_given,
                input blksize_value, input timeout_given, input timeout_value,
                input tsize_given, input tsize_value, output ready);
endinterface
`default_nettype wire

// File: design/tftp_request_option_parser_unit.sv
// TFTP request option parser, top level: input register, parse state,
// result register and the block size limit register.
// Depends on trop_pkg, trop_if (trop_req_if, trop_rsp_if) and trop_step.
//
// Usage
//   req_chan carries one packet byte per item, opcode bytes first, with
//   last_byte marking the final byte of the packet. Every request item gives
//   exactly one item on rsp_chan: a filename or lowercased mode byte with its
//   kind, and on the last byte or the first error, done_res with the status,
//   opcode and parsed options. After an error the remaining bytes give empty
//   items up to and including the last byte.
//   csr_write_enable / csr_write_data set max_block_size; write it only while
//   no item is in flight.
// Timing
//   An item taken from req_chan is held in the input register, parsed by
//   trop_step as it advances and shown on rsp_chan from the result register.
//   Throughput one item per cycle while rsp_chan is not stalled, set by the
//   combinational parse state loop through trop_step.
// Reset and stall
//   Reset (synchronous) empties both stages, returns the parse state to the
//   opcode phase and sets max_block_size to 65464. While rsp_chan is stalled
//   the result is held; one more item waits in the input register, after
//   which req_chan.ready drops.
`default_nettype none
module tftp_request_option_parser_unit #(
   parameter int unsigned TOKEN_MAX = trop_pkg::TOKEN_MAX_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   trop_req_if.sink          req_chan,
   trop_rsp_if.source        rsp_chan,
   input  logic              csr_write_enable,
   input  logic [15:0]       csr_write_data
);
   import trop_pkg::*;

   localparam int unsigned TL_W = $clog2(TOKEN_MAX + 1);

   logic            in_valid_ff;
   logic [7:0]      in_byte_ff;
   logic            in_last_ff;
   logic            out_valid_ff;
   result_type      out_res_ff;
   result_type      out_res_in;
   parse_state_type state_ff;
   parse_state_type state_in;
   logic [TL_W-1:0] tok_len_ff;
   logic [TL_W-1:0] tok_len_in;
   logic [15:0]     max_blk_ff;
   logic            advance;
   logic            take;

   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign take           = req_chan.valid && req_chan.ready;

   trop_step #(
      .TOKEN_MAX(TOKEN_MAX)
   ) u_step (
      .state_cur     (state_ff),
      .tok_len_cur   (tok_len_ff),
      .packet_byte   (in_byte_ff),
      .last_byte     (in_last_ff),
      .max_block_size(max_blk_ff),
      .state_nxt     (state_in),
      .tok_len_nxt   (tok_len_in),
      .result        (out_res_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= parse_reset_value();
         tok_len_ff   <= '0;
         max_blk_ff   <= MAX_BLOCK_SIZE_RESET;
      end else begin
         if (take) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            state_ff     <= state_in;
            tok_len_ff   <= tok_len_in;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
         if (csr_write_enable) begin
            max_blk_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_byte_ff <= req_chan.packet_byte;
         in_last_ff <= req_chan.last_byte;
      end
      if (advance) begin
         out_res_ff <= out_res_in;
      end
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.text_byte      = out_res_ff.text_byte;
   assign rsp_chan.text_kind      = out_res_ff.text_kind;
   assign rsp_chan.done_res       = out_res_ff.done_res;
   assign rsp_chan.status         = out_res_ff.status;
   assign rsp_chan.request_opcode = out_res_ff.request_opcode;
   assign rsp_chan.blksize_given  = out_res_ff.blksize_given;
   assign rsp_chan.blksize_value  = out_res_ff.blksize_value;
   assign rsp_chan.timeout_given  = out_res_ff.timeout_given;
   assign rsp_chan.timeout_value  = out_res_ff.timeout_value;
   assign rsp_chan.tsize_given    = out_res_ff.tsize_given;
   assign rsp_chan.tsize_value    = out_res_ff.tsize_value;

   a_status_only_when_done: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_res_ff.done_res |-> out_res_ff.status == ST_OK)
      else $error("nonzero status on an item that is not done");

   a_no_text_on_error: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_res_ff.status != ST_OK |-> out_res_ff.text_kind == KIND_NONE)
      else $error("text byte passed on an error item");

   a_last_resets_state: assert property (@(posedge clock) disable iff (reset)
      advance && in_last_ff |=> state_ff.phase == PH_OPC_HI && !state_ff.err
                                && tok_len_ff == '0)
      else $error("parse state not back to start after last byte");

   a_token_bound: assert property (@(posedge clock) disable iff (reset)
      tok_len_ff <= TL_W'(TOKEN_MAX))
      else $error("token length beyond limit");

endmodule
`default_nettype wire

// File: design/trop_step.sv
// One-byte parse step: next parse state and result item from the current
// state and one packet byte. Depends on trop_pkg.
`default_nettype none
module trop_step #(
   parameter int unsigned TOKEN_MAX = trop_pkg::TOKEN_MAX_DEFAULT,
   localparam int unsigned TL_W     = $clog2(TOKEN_MAX + 1)
) (
   input  trop_pkg::parse_state_type state_cur,
   input  logic [TL_W-1:0]           tok_len_cur,
   input  logic [7:0]                packet_byte,
   input  logic                      last_byte,
   input  logic [15:0]               max_block_size,
   output trop_pkg::parse_state_type state_nxt,
   output logic [TL_W-1:0]           tok_len_nxt,
   output trop_pkg::result_type      result
);
   import trop_pkg::*;

   logic [7:0]  lc;
   logic [2:0]  idx;
   logic [35:0] acc_wide;
   logic [31:0] v;
   logic [2:0]  status;
   logic [1:0]  tkind;
   logic [7:0]  tbyte;
   logic        done;

   assign lc  = to_lower(packet_byte);
   assign idx = tok_len_cur[2:0];
   assign v   = state_cur.acc;
   assign acc_wide = (36'(state_cur.acc) << 3) + (36'(state_cur.acc) << 1)
                     + 36'(packet_byte - CH_ZERO);

   always_comb begin
      state_nxt   = state_cur;
      tok_len_nxt = tok_len_cur;
      status      = ST_OK;
      tkind       = KIND_NONE;
      tbyte       = '0;
      done        = 1'b0;
      result      = '0;
      if (state_cur.err) begin
         if (last_byte) begin
            state_nxt   = parse_reset_value();
            tok_len_nxt = '0;
         end
      end else begin
         if (last_byte && state_cur.byte_count < BYTE_COUNT_MIN) begin
            status = ST_MALFORMED;
         end else begin
            if (state_cur.byte_count < BYTE_COUNT_SAT) begin
               state_nxt.byte_count = state_cur.byte_count + 3'd1;
            end
            priority if (state_cur.phase == PH_OPC_HI) begin
               state_nxt.opcode = {packet_byte, 8'h00};
               state_nxt.phase  = PH_OPC_LO;
            end else if (state_cur.phase == PH_OPC_LO) begin
               state_nxt.opcode = {state_cur.opcode[15:8], packet_byte};
               tok_len_nxt      = '0;
               state_nxt.phase  = PH_NAME;
            end else if (tok_len_cur >= TL_W'(TOKEN_MAX)) begin
               status = ST_TOO_LONG;
            end else begin
               unique case (state_cur.phase)
                  PH_NAME, PH_MODE: begin
                     tkind       = (state_cur.phase == PH_NAME) ? KIND_NAME : KIND_MODE;
                     tbyte       = (state_cur.phase == PH_NAME) ? packet_byte : lc;
                     tok_len_nxt = tok_len_cur + TL_W'(1);
                     if (packet_byte == CH_NUL) begin
                        tok_len_nxt     = '0;
                        state_nxt.phase = (state_cur.phase == PH_NAME) ? PH_MODE : PH_OPT;
                     end
                  end
                  PH_OPT: begin
                     if (packet_byte == CH_NUL) begin
                        priority if (state_cur.match_flags[0]
                                     && tok_len_cur == TL_W'(KW_BLKSIZE_LEN)) begin
                           state_nxt.target    = TGT_BLK;
                           state_nxt.blk_given = 1'b1;
                        end else if (state_cur.match_flags[1]
                                     && tok_len_cur == TL_W'(KW_TIMEOUT_LEN)) begin
                           state_nxt.target    = TGT_TMO;
                           state_nxt.tmo_given = 1'b1;
                        end else if (state_cur.match_flags[2]
                                     && tok_len_cur == TL_W'(KW_TSIZE_LEN)) begin
                           state_nxt.target    = TGT_TSZ;
                           state_nxt.tsz_given = 1'b1;
                        end else begin
                           state_nxt.target = TGT_NONE;
                        end
                        tok_len_nxt           = '0;
                        state_nxt.match_flags = FLAGS_ALL;
                        state_nxt.acc         = '0;
                        state_nxt.phase       = PH_VAL;
                     end else begin
                        if (tok_len_cur >= TL_W'(KW_BLKSIZE_LEN) || blksize_char(idx) != lc) begin
                           state_nxt.match_flags[0] = 1'b0;
                        end
                        if (tok_len_cur >= TL_W'(KW_TIMEOUT_LEN) || timeout_char(idx) != lc) begin
                           state_nxt.match_flags[1] = 1'b0;
                        end
                        if (tok_len_cur >= TL_W'(KW_TSIZE_LEN) || tsize_char(idx) != lc) begin
                           state_nxt.match_flags[2] = 1'b0;
                        end
                        tok_len_nxt = tok_len_cur + TL_W'(1);
                     end
                  end
                  PH_VAL: begin
                     if (packet_byte == CH_NUL) begin
                        unique case (state_cur.target)
                           TGT_TMO: begin
                              if (v == 32'd0 || v > 32'd255) begin
                                 status = ST_RANGE;
                              end else begin
                                 state_nxt.tmo_value = v[7:0];
                              end
                           end
                           TGT_BLK: begin
                              if (v < 32'd8) begin
                                 status = ST_RANGE;
                              end else if (v > 32'(max_block_size)) begin
                                 state_nxt.blk_value = max_block_size;
                              end else begin
                                 state_nxt.blk_value = v[15:0];
                              end
                           end
                           TGT_TSZ: begin
                              if (v == 32'd0) begin
                                 status = ST_RANGE;
                              end else begin
                                 state_nxt.tsz_value = v;
                              end
                           end
                           default: ;
                        endcase
                        tok_len_nxt     = '0;
                        state_nxt.acc   = '0;
                        state_nxt.phase = PH_OPT;
                     end else if (state_cur.target == TGT_NONE) begin
                        // unknown option: value bytes dropped
                     end else if (packet_byte >= CH_ZERO && packet_byte <= CH_NINE) begin
                        state_nxt.acc = (acc_wide[35:32] != 4'd0) ? 32'hFFFF_FFFF
                                                                  : acc_wide[31:0];
                        tok_len_nxt   = tok_len_cur + TL_W'(1);
                     end else begin
                        status = ST_BAD_DIGIT;
                     end
                  end
                  default: ;
               endcase
            end
            if (status == ST_OK && last_byte) begin
               priority if (state_nxt.blk_given && state_nxt.blk_value == 16'd0) begin
                  status = ST_MISSING_VAL;
               end else if (state_nxt.tmo_given && state_nxt.tmo_value == 8'd0) begin
                  status = ST_MISSING_VAL;
               end else if (state_nxt.tsz_given && state_nxt.tsz_value == 32'd0) begin
                  status = ST_MISSING_VAL;
               end else if (packet_byte != CH_NUL) begin
                  status = ST_MALFORMED;
               end else begin
               end
            end
         end
         if (status != ST_OK) begin
            done  = 1'b1;
            tbyte = '0;
            tkind = KIND_NONE;
         end
         if (last_byte) begin
            done = 1'b1;
         end
         result.text_byte = tbyte;
         result.text_kind = tkind;
         if (done) begin
            result.done_res       = 1'b1;
            result.status         = status;
            result.request_opcode = state_nxt.opcode;
            result.blksize_given  = state_nxt.blk_given;
            result.blksize_value  = state_nxt.blk_value;
            result.timeout_given  = state_nxt.tmo_given;
            result.timeout_value  = state_nxt.tmo_value;
            result.tsize_given    = state_nxt.tsz_given;
            result.tsize_value    = state_nxt.tsz_value;
         end
         if (last_byte) begin
            state_nxt   = parse_reset_value();
            tok_len_nxt = '0;
         end else if (status != ST_OK) begin
            state_nxt.err = 1'b1;
         end
      end
   end

endmodule
`default_nettype wire
